### design/mfe_pkg.sv
// Package for the marker field extractor: shared types, register indexes,
// result kinds and reset values. No dependencies.
`default_nettype none
package mfe_pkg;

	// Default sizes handed to the top level parameters.
	localparam int MARKER_BYTES_DEF = 8;
	localparam int FIELD_BYTES_DEF  = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARKER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MARKER      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR_BYTE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELDS_WANTED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MATCHES_TO_SKIP = 3'd4;

	localparam logic [63:0] HIGH_MARKER_RST     = 64'h642D74656D70223E;
	localparam logic [63:0] LOW_MARKER_RST      = 64'h6E2D74656D70223E;
	localparam logic [7:0]  TERMINATOR_BYTE_RST = 8'hC2;
	localparam logic [3:0]  FIELDS_WANTED_RST   = 4'd7;
	localparam logic [1:0]  MATCHES_TO_SKIP_RST = 2'd1;

	// Result kinds, carried on tuser.
	localparam logic [1:0] KIND_HIGH   = 2'd0;
	localparam logic [1:0] KIND_LOW    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Match counter: skip (max 3) plus wanted (max 15) fits in five bits.
	localparam int CNT_W = 5;

	// Only the first three captured bytes are ever shown.
	localparam int SHOW_BYTES = 3;

	// Output word queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam int OUT_TDATA_W = 40;

	typedef struct packed {
		logic [3:0] field_index;
		logic [7:0] char_first;
		logic [7:0] char_second;
		logic [7:0] char_third;
		logic [1:0] char_count;
		logic       overflowed;
	} field_res_t;

	typedef struct packed {
		logic [1:0] kind;
		field_res_t fld;
		logic [1:0] end_status;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

### design/mfe_marker_lane.sv
// Per-marker match counting and field capture for the marker field extractor.
// Depends on mfe_pkg.
`default_nettype none
module mfe_marker_lane
	import mfe_pkg::*;
#(
	parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       hit,
	input  wire logic [7:0] terminator,
	input  wire logic [3:0] wanted,
	input  wire logic [1:0] skip,
	output logic            emit,
	output field_res_t      field,
	output logic            short_flag
);

	localparam int LEN_W = $clog2(FIELD_BYTES + 1);

	logic [CNT_W-1:0] cnt_q, cnt_nx, limit;
	logic             cap_q, cap_nx;
	logic [LEN_W-1:0] len_q, len_nx;
	logic             ovf_q, ovf_nx;
	logic [7:0]       bytes_q [SHOW_BYTES];
	logic             term_hit, store_en;
	logic [1:0]       shown;

	always_comb begin
		limit    = CNT_W'(skip) + CNT_W'(wanted);
		term_hit = (data_byte == terminator);
		store_en = 1'b0;
		cnt_nx   = cnt_q;
		cap_nx   = cap_q;
		len_nx   = len_q;
		ovf_nx   = ovf_q;
		if (cap_q) begin
			if (term_hit) begin
				cap_nx = 1'b0;
				len_nx = '0;
				ovf_nx = 1'b0;
			end else if (int'(len_q) < FIELD_BYTES) begin
				store_en = 1'b1;
				len_nx   = len_q + LEN_W'(1);
			end else begin
				ovf_nx = 1'b1;
			end
		end else if (cnt_q < limit && hit) begin
			if (cnt_q >= CNT_W'(skip)) begin
				cap_nx = 1'b1;
				len_nx = '0;
				ovf_nx = 1'b0;
			end
			cnt_nx = cnt_q + CNT_W'(1);
		end
		short_flag = cap_nx || (cnt_nx < limit);
	end

	// The field word is built from the state before this byte.
	always_comb begin
		if (int'(len_q) > SHOW_BYTES) begin
			shown = 2'd3;
		end else begin
			shown = 2'(len_q);
		end
		emit              = take && cap_q && term_hit;
		field.field_index = 4'(cnt_q - CNT_W'(1) - CNT_W'(skip));
		field.char_first  = (shown > 2'd0) ? bytes_q[0] : 8'd0;
		field.char_second = (shown > 2'd1) ? bytes_q[1] : 8'd0;
		field.char_third  = (shown > 2'd2) ? bytes_q[2] : 8'd0;
		field.char_count  = shown;
		field.overflowed  = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= 1'b0;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q <= '0;
				cap_q <= 1'b0;
				len_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_nx;
				cap_q <= cap_nx;
				len_q <= len_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

	// Captured bytes are payload; unwritten slots are masked by the length.
	always_ff @(posedge clk) begin
		for (int k = 0; k < SHOW_BYTES; k++) begin
			if (take && store_en && k < FIELD_BYTES && int'(len_q) == k) begin
				bytes_q[k] <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

### design/marker_field_extractor.sv
// Top level of the marker field extractor: byte window, two marker lanes,
// configuration registers and the output word queue. Depends on mfe_pkg
// and mfe_marker_lane.
//
// Channel   Direction  Word                          Notes
// s_*       in         one stream byte per word      tlast marks the final byte
// m_*       out        one field or status word      tuser = kind, tlast = last
// cfg_*     in         register write                no wait, no read-back
//
// One input byte is taken per cycle while s_tready is high. Its window
// compare, field capture and result words are settled combinationally and
// written into a four-word output queue in the same cycle. A byte yields
// zero to three words and the queue drains one word per cycle with m_tready
// high, so s_tready is high whenever at most one word is queued; a byte
// that yields two or three words can hold the input off. arst_n clears
// the window, all lane state and the queue at once and loads the register
// defaults; there is no clearing pass. A stalled m_tready only fills the
// queue; the input side stops when fewer than three slots are free.
`default_nettype none
module marker_field_extractor
	import mfe_pkg::*;
#(
	parameter int MARKER_BYTES = MARKER_BYTES_DEF,
	parameter int FIELD_BYTES  = FIELD_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream: tdata = data_byte [7:0]; tlast = last_byte.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  s_tlast,
	// Output stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tdata: field_index [3:0], char_first [11:4], char_second [19:12],
	// char_third [27:20], char_count [29:28], overflowed [30],
	// end_status [32:31], zero fill [39:33].
	output logic [OUT_TDATA_W-1:0]     m_tdata,
	// tuser: result_kind [1:0].
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast,
	// Configuration writes.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WIN_W  = 8 * MARKER_BYTES;
	localparam int FILL_W = $clog2(MARKER_BYTES + 1);
	localparam int ACCEPT_MAX = FIFO_DEPTH - 3;

	// Configuration registers.
	logic [63:0] high_marker_q, low_marker_q;
	logic [7:0]  terminator_q;
	logic [3:0]  wanted_q;
	logic [1:0]  skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_marker_q <= HIGH_MARKER_RST;
			low_marker_q  <= LOW_MARKER_RST;
			terminator_q  <= TERMINATOR_BYTE_RST;
			wanted_q      <= FIELDS_WANTED_RST;
			skip_q        <= MATCHES_TO_SKIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGH_MARKER:     high_marker_q <= cfg_wdata;
				REG_LOW_MARKER:      low_marker_q  <= cfg_wdata;
				REG_TERMINATOR_BYTE: terminator_q  <= cfg_wdata[7:0];
				REG_FIELDS_WANTED:   wanted_q      <= cfg_wdata[3:0];
				REG_MATCHES_TO_SKIP: skip_q        <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	logic take;
	assign take = s_tvalid && s_tready;

	// Byte window. The compare looks at the window after this byte is
	// shifted in, and only once a full marker's worth of bytes has arrived.
	logic [WIN_W-1:0]  window_q, window_nx;
	logic [FILL_W-1:0] fill_q, fill_nx;
	logic              full_nx, high_hit, low_hit;

	always_comb begin
		window_nx = WIN_W'({window_q, s_tdata});
		fill_nx   = (fill_q == FILL_W'(MARKER_BYTES)) ? fill_q : fill_q + FILL_W'(1);
		full_nx   = (fill_nx == FILL_W'(MARKER_BYTES));
		high_hit  = full_nx && (window_nx == high_marker_q[WIN_W-1:0]);
		low_hit   = full_nx && (window_nx == low_marker_q[WIN_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (take) begin
			if (s_tlast) begin
				window_q <= '0;
				fill_q   <= '0;
			end else begin
				window_q <= window_nx;
				fill_q   <= fill_nx;
			end
		end
	end

	// Marker lanes.
	logic       high_emit, low_emit, high_short, low_short;
	field_res_t high_field, low_field;

	mfe_marker_lane #(.FIELD_BYTES(FIELD_BYTES)) u_high_lane (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.hit        (high_hit),
		.terminator (terminator_q),
		.wanted     (wanted_q),
		.skip       (skip_q),
		.emit       (high_emit),
		.field      (high_field),
		.short_flag (high_short)
	);

	mfe_marker_lane #(.FIELD_BYTES(FIELD_BYTES)) u_low_lane (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.hit        (low_hit),
		.terminator (terminator_q),
		.wanted     (wanted_q),
		.skip       (skip_q),
		.emit       (low_emit),
		.field      (low_field),
		.short_flag (low_short)
	);

	// Candidate words in output order: first marker, second marker, status.
	// They are packed into consecutive queue slots, and the final one of
	// this byte carries the last flag.
	result_t    cand [3];
	logic [2:0] cand_v;
	result_t    push [3];
	logic [1:0] push_n;

	always_comb begin
		cand_v = {take && s_tlast, low_emit, high_emit};

		cand[0].kind       = KIND_HIGH;
		cand[0].fld        = high_field;
		cand[0].end_status = 2'd0;
		cand[0].last       = !cand_v[1] && !cand_v[2];

		cand[1].kind       = KIND_LOW;
		cand[1].fld        = low_field;
		cand[1].end_status = 2'd0;
		cand[1].last       = !cand_v[2];

		cand[2].kind       = KIND_STATUS;
		cand[2].fld        = '0;
		cand[2].end_status = {low_short, high_short};
		cand[2].last       = 1'b1;

		push_n = 2'd0;
		for (int k = 0; k < 3; k++) begin
			push[k] = cand[2];
		end
		for (int k = 0; k < 3; k++) begin
			if (cand_v[k]) begin
				push[push_n] = cand[k];
				push_n       = push_n + 2'd1;
			end
		end
	end

	// Output word queue.
	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign s_tready = (cnt_q <= FIFO_CNT_W'(ACCEPT_MAX));
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (k < int'(push_n)) begin
				fifo_q[FIFO_PTR_W'(wr_ptr_q + FIFO_PTR_W'(k))] <= push[k];
			end
		end
	end

	result_t head;
	assign head    = fifo_q[rd_ptr_q];
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = OUT_TDATA_W'({head.end_status, head.fld.overflowed, head.fld.char_count,
		head.fld.char_third, head.fld.char_second, head.fld.char_first,
		head.fld.field_index});

	// The queue never holds more words than it has slots.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("output queue overfilled");

	// A byte is only taken when its worst case of three words fits.
	a_room_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("byte taken without room for its words");

	// The status word always closes the words of its byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
		else $error("status word without last flag");

	// Field words carry no end status.
	a_field_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_STATUS) |-> (m_tdata[32:31] == 2'd0))
		else $error("field word with end status set");

	// The final byte of a stream leaves the window empty.
	a_stream_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && s_tlast) |=> (fill_q == '0))
		else $error("window not cleared after final byte");

endmodule
`default_nettype wire

### verif/marker_field_extractor_checker.sv
`timescale 1ns / 1ps
// Checker for the marker field extractor: watches the byte, result and register
// channels, predicts every result word and compares it field by field.
// Depends on mfe_pkg.
module marker_field_extractor_checker
	import mfe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [7:0]             s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [1:0]             m_tuser,
	input  logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     errors,
	output int                     words_owed
);
	localparam logic [63:0] WINDOW_MASK = {64{1'b1}} >> (64 - 8 * MARKER_BYTES_DEF);

	// Register copy, index 0 is the first marker lane.
	logic [63:0] marker_val [2];
	logic [7:0]  term_byte;
	logic [3:0]  wanted;
	logic [1:0]  skip;

	// Stream state.
	logic [63:0] window;
	logic [3:0]  fill;
	logic [4:0]  match_cnt [2];
	logic        capturing [2];
	logic [23:0] cap_bytes [2];
	logic [1:0]  cap_len [2];
	logic        cap_ovf [2];

	result_t step_rows [3];
	int      step_n;
	result_t owed_fields [$];

	initial errors = 0;
	initial words_owed = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (errors < 40)
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	task automatic clear_stream();
		window = '0;
		fill = '0;
		for (int l = 0; l < 2; l++) begin
			match_cnt[l] = '0;
			capturing[l] = 1'b0;
			cap_bytes[l] = '0;
			cap_len[l] = '0;
			cap_ovf[l] = 1'b0;
		end
	endtask

	function automatic logic lane_short(input int lane);
		return capturing[lane] || int'(match_cnt[lane]) < int'(skip) + int'(wanted);
	endfunction

	// One byte through one marker lane; a finished capture lands in step_rows.
	task automatic lane_step(input int lane, input logic [7:0] b, input logic [1:0] kind);
		int      limit;
		result_t row;
		limit = int'(skip) + int'(wanted);
		row = '0;
		if (capturing[lane]) begin
			if (b == term_byte) begin
				row.kind = kind;
				row.fld.field_index = 4'(match_cnt[lane] - 5'd1 - 5'(skip));
				row.fld.char_first = (cap_len[lane] > 2'd0) ? cap_bytes[lane][7:0] : 8'h00;
				row.fld.char_second = (cap_len[lane] > 2'd1) ? cap_bytes[lane][15:8] : 8'h00;
				row.fld.char_third = (cap_len[lane] > 2'd2) ? cap_bytes[lane][23:16] : 8'h00;
				row.fld.char_count = cap_len[lane];
				row.fld.overflowed = cap_ovf[lane];
				step_rows[step_n] = row;
				step_n++;
				capturing[lane] = 1'b0;
				cap_bytes[lane] = '0;
				cap_len[lane] = '0;
				cap_ovf[lane] = 1'b0;
			end else if (int'(cap_len[lane]) < FIELD_BYTES_DEF) begin
				cap_bytes[lane][8 * cap_len[lane] +: 8] = b;
				cap_len[lane] = cap_len[lane] + 2'd1;
			end else begin
				cap_ovf[lane] = 1'b1;
			end
		end else if (int'(match_cnt[lane]) < limit && int'(fill) >= MARKER_BYTES_DEF
				&& ((window ^ marker_val[lane]) & WINDOW_MASK) == '0) begin
			if (match_cnt[lane] >= 5'(skip)) begin
				capturing[lane] = 1'b1;
				cap_bytes[lane] = '0;
				cap_len[lane] = '0;
				cap_ovf[lane] = 1'b0;
			end
			match_cnt[lane] = match_cnt[lane] + 5'd1;
		end
	endtask

	task automatic extract_byte(input logic [7:0] b, input logic fin);
		result_t row;
		step_n = 0;
		window = {window[55:0], b};
		if (fill < 4'd8)
			fill = fill + 4'd1;
		lane_step(0, b, KIND_HIGH);
		lane_step(1, b, KIND_LOW);
		if (fin) begin
			row = '0;
			row.kind = KIND_STATUS;
			row.end_status = {lane_short(1), lane_short(0)};
			step_rows[step_n] = row;
			step_n++;
			clear_stream();
		end
		if (step_n > 0)
			step_rows[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			owed_fields.push_back(step_rows[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			marker_val[0] = HIGH_MARKER_RST;
			marker_val[1] = LOW_MARKER_RST;
			term_byte = TERMINATOR_BYTE_RST;
			wanted = FIELDS_WANTED_RST;
			skip = MATCHES_TO_SKIP_RST;
			clear_stream();
			owed_fields.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HIGH_MARKER:     marker_val[0] = cfg_wdata;
					REG_LOW_MARKER:      marker_val[1] = cfg_wdata;
					REG_TERMINATOR_BYTE: term_byte = cfg_wdata[7:0];
					REG_FIELDS_WANTED:   wanted = cfg_wdata[3:0];
					REG_MATCHES_TO_SKIP: skip = cfg_wdata[1:0];
					default: ;
				endcase
			end
			// A word leaving now was caused by an earlier byte, so compare first.
			if (m_tvalid && m_tready) begin
				if (owed_fields.size() == 0) begin
					report("unexpected word", 64'(m_tdata), '0);
				end else begin
					want = owed_fields.pop_front();
					check_field("result_kind", m_tuser, want.kind);
					check_field("field_index", m_tdata[3:0], want.fld.field_index);
					check_field("char_first", m_tdata[11:4], want.fld.char_first);
					check_field("char_second", m_tdata[19:12], want.fld.char_second);
					check_field("char_third", m_tdata[27:20], want.fld.char_third);
					check_field("char_count", m_tdata[29:28], want.fld.char_count);
					check_field("overflowed", m_tdata[30], want.fld.overflowed);
					check_field("end_status", m_tdata[32:31], want.end_status);
					check_field("zero fill", m_tdata[39:33], '0);
					check_field("last_result", m_tlast, want.last);
				end
			end
			if (s_tvalid && s_tready)
				extract_byte(s_tdata, s_tlast);
		end
		words_owed = owed_fields.size();
	end

endmodule

### verif/marker_field_extractor_test.sv
`timescale 1ns / 1ps
// Testbench top for the marker field extractor: drives bytes and register
// writes, stalls the result side, and gives the verdict.
// Depends on mfe_pkg, marker_field_extractor and marker_field_extractor_checker.
module marker_field_extractor_test;
	import mfe_pkg::*;

	localparam int HALF_PERIOD = 6;
	// The random loop stops starting new phases once this many bytes have gone
	// out; the phase under way runs on past it.
	localparam int TOTAL_BYTES = 350;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [7:0]            s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	int errors;
	int words_owed;

	// When calm is set, neither side inserts idle cycles, so that stretches of
	// back-to-back traffic are exercised as well.
	bit calm = 1'b0;

	// The register values the stimulus believes are loaded; used to build
	// marker sequences that actually hit.
	logic [63:0] high_now;
	logic [63:0] low_now;
	logic [7:0]  term_now;
	int          bytes_sent = 0;

	always #HALF_PERIOD clk = ~clk;

	marker_field_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	marker_field_extractor_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.words_owed (words_owed)
	);

	// Hard stop, in case the run hangs.
	initial begin : watchdog
		#(2400000);
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: before each word, hold tready low for a random number of
	// cycles, then keep it high until a word has been taken.
	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one byte after a random gap and returns at the edge that takes it.
	// tvalid stays high on return, so a following byte with no gap goes out
	// back to back.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Stops the byte side and waits for every predicted word to come out. The
	// block settles a byte in the cycle it takes it, so a few spare cycles
	// cover bytes that produced no word.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write of a batch
	// so that back-to-back writes never toggle it within one edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_HIGH_MARKER:     high_now = val;
			REG_LOW_MARKER:      low_now = val;
			REG_TERMINATOR_BYTE: term_now = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [63:0] pick_marker(input logic [63:0] other);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			// Both lanes on one marker, so both can finish on the same byte.
			2: return other;
			// Shared tail: the two markers differ only early in the window.
			3: return {8'($urandom), other[55:0]};
			4: return {$urandom(), other[31:0]};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [7:0] pick_terminator();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return TERMINATOR_BYTE_RST;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_wanted();
		case ($urandom_range(0, 5))
			// Zero wanted: the marker never captures.
			0: return 4'd0;
			1: return 4'd1;
			2: return 4'd15;
			default: return 4'($urandom_range(1, 15));
		endcase
	endfunction

	// Reprograms a random subset of the registers, or all of them, with the
	// byte side quiet and nothing left in flight. A stream may still be open
	// here, which covers lowering fields_wanted in the middle of a stream.
	task automatic retune(input bit all_regs);
		drain();
		if (all_regs || $urandom_range(0, 1) == 1)
			write_reg(REG_HIGH_MARKER, pick_marker(low_now));
		if (all_regs || $urandom_range(0, 1) == 1)
			write_reg(REG_LOW_MARKER, pick_marker(high_now));
		if (all_regs || $urandom_range(0, 1) == 1)
			write_reg(REG_TERMINATOR_BYTE, 64'(pick_terminator()));
		if (all_regs || $urandom_range(0, 1) == 1)
			write_reg(REG_FIELDS_WANTED, 64'(pick_wanted()));
		if (all_regs || $urandom_range(0, 1) == 1)
			write_reg(REG_MATCHES_TO_SKIP, 64'($urandom_range(0, 3)));
		cfg_we <= 1'b0;
	endtask

	// A marker followed by a short field and its terminator. Now and then the
	// marker is cut short, or the terminator is left out so that the capture
	// stays open until a later terminator or the end of the stream.
	task automatic send_record(input bit lane);
		logic [63:0] mk;
		logic [7:0]  b;
		int          cut;
		int          len;
		mk = lane ? low_now : high_now;
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
		for (int i = 7; i > 7 - cut; i--)
			send_byte(mk[8 * i +: 8], 1'b0);
		if (cut < 8)
			return;
		len = $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (b == term_now && $urandom_range(0, 3) != 0)
				b = ~b;
			send_byte(b, 1'b0);
		end
		if ($urandom_range(0, 7) != 0)
			send_byte(term_now, 1'b0);
	endtask

	// Records with noise in between; with finish set, a closing byte carries tlast,
	// and is sometimes the terminator so that a field and the status share a byte.
	task automatic send_stream(input bit finish);
		int recs;
		recs = $urandom_range(0, 10);
		repeat (recs) begin
			repeat ($urandom_range(0, 3))
				send_byte(8'($urandom), 1'b0);
			send_record(1'($urandom_range(0, 1)));
		end
		if (finish)
			send_byte(($urandom_range(0, 3) == 0) ? term_now : 8'($urandom), 1'b1);
	endtask

	initial begin : stimulus
		high_now = HIGH_MARKER_RST;
		low_now = LOW_MARKER_RST;
		term_now = TERMINATOR_BYTE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with defaults except no skipped match and one field
		// wanted per marker. The first marker opens a capture that takes the
		// byte extremes and then overflows on the second marker; the closing
		// terminator also carries tlast, so one byte yields the overflowed
		// field, an empty field and the status, all in one go.
		write_reg(REG_MATCHES_TO_SKIP, 64'd0);
		write_reg(REG_FIELDS_WANTED, 64'd1);
		cfg_we <= 1'b0;
		for (int i = 7; i >= 0; i--)
			send_byte(high_now[8 * i +: 8], 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		for (int i = 7; i >= 0; i--)
			send_byte(low_now[8 * i +: 8], 1'b0);
		send_byte(term_now, 1'b1);
		// A one-byte stream: both markers come up short.
		send_byte(8'hFF, 1'b1);

		// Random part: every register is loaded once, then phases of streams
		// with reprogramming in between.
		retune(1'b1);
		while (bytes_sent < TOTAL_BYTES) begin
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				send_stream(1'b1);
			send_stream($urandom_range(0, 4) == 0);
			retune($urandom_range(0, 3) == 0);
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/mfe_pkg.sv
design/mfe_marker_lane.sv
design/marker_field_extractor.sv
verif/marker_field_extractor_checker.sv
verif/marker_field_extractor_test.sv
